// ----- rtl/lpu_pkg.sv -----
// ----------------------------------------------------------------------------
// lpu_pkg
// shared types, constants and fixed-point helpers of the leapfrog update
// ----------------------------------------------------------------------------
package lpu_pkg;

    localparam int N_AXES     = 3;
    localparam int N_STAGES   = 8;

    localparam int W_DATA     = 32;
    localparam int W_ELEM     = 21;
    localparam int W_PACK     = 63;
    localparam int W_TYPE     = 3;
    localparam int W_TF       = 9;
    localparam int W_CFG_IDX  = 3;
    localparam int W_CFG_DATA = 63;

    // widths of the intermediate terms handed from the front to an axis
    localparam int W_FM_SH    = 49;
    localparam int W_DOT_SH   = 39;
    localparam int W_BASE     = 37;

    // type_and_freeze field positions
    localparam int TF_VSITE_LSB = 3;
    localparam int TF_SHELL_LSB = 6;

    // pipeline stage numbers
    localparam int ST_VREL   = 0;
    localparam int ST_MUL    = 1;
    localparam int ST_SUM    = 2;
    localparam int ST_BR     = 3;
    localparam int ST_BRMUL  = 4;
    localparam int ST_VEL    = 5;
    localparam int ST_POSMUL = 6;
    localparam int ST_OUT    = 7;

    typedef enum logic [W_CFG_IDX-1:0] {
        REG_TIME_STEP,
        REG_TEMP_SCALE,
        REG_ROW_X,
        REG_ROW_Y,
        REG_ROW_Z,
        REG_MEAN_FLOW,
        REG_GROUP_ACCEL,
        REG_TYPE_FREEZE
    } t_cfg_reg;

    typedef struct packed {
        logic signed [W_DATA-1:0] pos_x;
        logic signed [W_DATA-1:0] pos_y;
        logic signed [W_DATA-1:0] pos_z;
        logic signed [W_DATA-1:0] vel_x;
        logic signed [W_DATA-1:0] vel_y;
        logic signed [W_DATA-1:0] vel_z;
        logic signed [W_DATA-1:0] force_x;
        logic signed [W_DATA-1:0] force_y;
        logic signed [W_DATA-1:0] force_z;
        logic        [W_DATA-1:0] inv_mass;
        logic        [W_TYPE-1:0] particle_type;
    } t_particle;

    typedef struct packed {
        logic signed [W_DATA-1:0] new_vel_x;
        logic signed [W_DATA-1:0] new_vel_y;
        logic signed [W_DATA-1:0] new_vel_z;
        logic signed [W_DATA-1:0] new_pos_x;
        logic signed [W_DATA-1:0] new_pos_y;
        logic signed [W_DATA-1:0] new_pos_z;
    } t_result;

    typedef struct packed {
        logic [W_DATA-1:0]              time_step;
        logic [W_DATA-1:0]              temp_scale;
        logic [N_AXES-1:0][W_PACK-1:0]  coupling_row;
        logic [W_PACK-1:0]              mean_flow;
        logic [W_PACK-1:0]              group_accel;
        logic [W_TF-1:0]                type_and_freeze;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        time_step:       '0,
        temp_scale:      32'h4000_0000,
        coupling_row:    '0,
        mean_flow:       '0,
        group_accel:     '0,
        type_and_freeze: '0
    };

    typedef struct packed {
        logic [N_STAGES-1:0] load;
    } t_pipe_ctl;

    typedef struct packed {
        logic signed [W_FM_SH-1:0]  fm_sh;
        logic signed [W_DOT_SH-1:0] dot_sh;
        logic signed [W_BASE-1:0]   base;
        logic signed [W_DATA-1:0]   pos;
        logic                       active;
    } t_axis_mid;

    localparam logic signed [63:0] SAT_MAX = 64'sh0000_0000_7FFF_FFFF;
    localparam logic signed [63:0] SAT_MIN = 64'shFFFF_FFFF_8000_0000;

    // clamp to signed 32 bits
    function automatic logic signed [W_DATA-1:0] sat32(input logic signed [63:0] v);
        logic signed [W_DATA-1:0] r;
        if (v > SAT_MAX) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < SAT_MIN) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[W_DATA-1:0];
        end
        return r;
    endfunction

    // signed 21-bit element k of a packed triple
    function automatic logic signed [W_ELEM-1:0] elem(input logic [W_PACK-1:0] pk,
                                                      input logic [1:0] k);
        return $signed(pk[W_ELEM*k +: W_ELEM]);
    endfunction

endpackage

// ----- rtl/lpu_if.sv -----
// ----------------------------------------------------------------------------
// lpu_particle_if / lpu_result_if
// valid/ready channels carrying one particle or one updated particle
// ----------------------------------------------------------------------------
interface lpu_particle_if;
    import lpu_pkg::*;
    logic      valid;
    logic      ready;
    t_particle data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface lpu_result_if;
    import lpu_pkg::*;
    logic    valid;
    logic    ready;
    t_result data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/lpu_cfg.sv -----
// ----------------------------------------------------------------------------
// lpu_cfg
// configuration register file, written through a plain write port
// ----------------------------------------------------------------------------
module lpu_cfg (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [lpu_pkg::W_CFG_IDX-1:0]    i_cfg_idx,
    input  logic [lpu_pkg::W_CFG_DATA-1:0]   i_cfg_data,
    output lpu_pkg::t_cfg                    o_cfg
);
    import lpu_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_idx))
                REG_TIME_STEP:   r_cfg.time_step       <= i_cfg_data[W_DATA-1:0];
                REG_TEMP_SCALE:  r_cfg.temp_scale      <= i_cfg_data[W_DATA-1:0];
                REG_ROW_X:       r_cfg.coupling_row[0] <= i_cfg_data[W_PACK-1:0];
                REG_ROW_Y:       r_cfg.coupling_row[1] <= i_cfg_data[W_PACK-1:0];
                REG_ROW_Z:       r_cfg.coupling_row[2] <= i_cfg_data[W_PACK-1:0];
                REG_MEAN_FLOW:   r_cfg.mean_flow       <= i_cfg_data[W_PACK-1:0];
                REG_GROUP_ACCEL: r_cfg.group_accel     <= i_cfg_data[W_PACK-1:0];
                REG_TYPE_FREEZE: r_cfg.type_and_freeze <= i_cfg_data[W_TF-1:0];
                default:         r_cfg                 <= r_cfg;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- rtl/lpu_front.sv -----
// ----------------------------------------------------------------------------
// lpu_front
// stages 1 to 3: relative velocity, row, force, lambda and accel products, dot sums and base term
// ----------------------------------------------------------------------------
module lpu_front (
    input  logic                i_clk,
    input  lpu_pkg::t_pipe_ctl  i_ctl,
    input  lpu_pkg::t_cfg       i_cfg,
    input  lpu_pkg::t_particle  i_part,
    output lpu_pkg::t_axis_mid  o_mid [lpu_pkg::N_AXES]
);
    import lpu_pkg::*;

    logic signed [W_DATA-1:0] in_pos [N_AXES];
    logic signed [W_DATA-1:0] in_vel [N_AXES];
    logic signed [W_DATA-1:0] in_frc [N_AXES];
    logic                     inert;

    // stage 1
    logic signed [W_DATA-1:0] n1_vrel [N_AXES];
    logic signed [W_DATA-1:0] r1_vrel [N_AXES];
    logic signed [W_DATA-1:0] r1_pos  [N_AXES];
    logic signed [W_DATA-1:0] r1_frc  [N_AXES];
    logic        [W_DATA-1:0] r1_imass;
    logic        [N_AXES-1:0] r1_active;

    // stage 2
    logic signed [52:0] n2_dprod [N_AXES][N_AXES];
    logic signed [64:0] n2_fm    [N_AXES];
    logic signed [64:0] n2_lt    [N_AXES];
    logic signed [53:0] n2_ga    [N_AXES];
    logic signed [52:0] r2_dprod [N_AXES][N_AXES];
    logic signed [64:0] r2_fm    [N_AXES];
    logic signed [64:0] r2_lt    [N_AXES];
    logic signed [53:0] r2_ga    [N_AXES];
    logic signed [W_DATA-1:0] r2_pos [N_AXES];
    logic        [N_AXES-1:0] r2_active;

    // stage 3
    logic signed [54:0] n3_dot [N_AXES];
    t_axis_mid          n3_mid [N_AXES];
    t_axis_mid          r3_mid [N_AXES];

    assign in_pos[0] = i_part.pos_x;
    assign in_pos[1] = i_part.pos_y;
    assign in_pos[2] = i_part.pos_z;
    assign in_vel[0] = i_part.vel_x;
    assign in_vel[1] = i_part.vel_y;
    assign in_vel[2] = i_part.vel_z;
    assign in_frc[0] = i_part.force_x;
    assign in_frc[1] = i_part.force_y;
    assign in_frc[2] = i_part.force_z;

    // virtual sites and shells are not integrated
    assign inert = (i_part.particle_type == i_cfg.type_and_freeze[TF_VSITE_LSB +: W_TYPE])
                || (i_part.particle_type == i_cfg.type_and_freeze[TF_SHELL_LSB +: W_TYPE]);

    always_comb begin
        for (int d = 0; d < N_AXES; d++) begin
            n1_vrel[d] = sat32(64'(in_vel[d]) - 64'(elem(i_cfg.mean_flow, 2'(d))));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[ST_VREL]) begin
            for (int d = 0; d < N_AXES; d++) begin
                r1_vrel[d]   <= n1_vrel[d];
                r1_pos[d]    <= in_pos[d];
                r1_frc[d]    <= in_frc[d];
                r1_active[d] <= !inert && !i_cfg.type_and_freeze[d];
            end
            r1_imass <= i_part.inv_mass;
        end
    end

    always_comb begin
        for (int d = 0; d < N_AXES; d++) begin
            for (int k = 0; k < N_AXES; k++) begin
                n2_dprod[d][k] = elem(i_cfg.coupling_row[d], 2'(k)) * r1_vrel[k];
            end
            n2_fm[d] = $signed({1'b0, r1_imass}) * r1_frc[d];
            n2_lt[d] = r1_vrel[d] * $signed({1'b0, i_cfg.temp_scale});
            n2_ga[d] = elem(i_cfg.group_accel, 2'(d)) * $signed({1'b0, i_cfg.time_step});
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[ST_MUL]) begin
            r2_dprod  <= n2_dprod;
            r2_fm     <= n2_fm;
            r2_lt     <= n2_lt;
            r2_ga     <= n2_ga;
            r2_pos    <= r1_pos;
            r2_active <= r1_active;
        end
    end

    // floor shifts are plain arithmetic part-selects of exact products
    always_comb begin
        for (int d = 0; d < N_AXES; d++) begin
            n3_dot[d] = 55'(r2_dprod[d][0]) + 55'(r2_dprod[d][1]) + 55'(r2_dprod[d][2]);
            n3_mid[d].fm_sh  = r2_fm[d][64:16];
            n3_mid[d].dot_sh = n3_dot[d][54:16];
            n3_mid[d].base   = W_BASE'(elem(i_cfg.mean_flow, 2'(d)))
                             + W_BASE'($signed(r2_ga[d][53:32]))
                             + W_BASE'($signed(r2_lt[d][64:30]));
            n3_mid[d].pos    = r2_pos[d];
            n3_mid[d].active = r2_active[d];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[ST_SUM]) begin
            r3_mid <= n3_mid;
        end
    end

    assign o_mid = r3_mid;

endmodule

// ----- rtl/lpu_axis.sv -----
// ----------------------------------------------------------------------------
// lpu_axis
// stages 4 to 8 of one axis: bracket times dt, new velocity, new position
// ----------------------------------------------------------------------------
module lpu_axis (
    input  logic                                  i_clk,
    input  lpu_pkg::t_pipe_ctl                    i_ctl,
    input  logic        [lpu_pkg::W_DATA-1:0]     i_time_step,
    input  lpu_pkg::t_axis_mid                    i_mid,
    output logic signed [lpu_pkg::W_DATA-1:0]     o_vel,
    output logic signed [lpu_pkg::W_DATA-1:0]     o_pos
);
    import lpu_pkg::*;

    logic signed [32:0] dt_s;

    // stage 4
    logic signed [49:0]       n4_br;
    logic signed [49:0]       r4_br;
    logic signed [W_BASE-1:0] r4_base;
    logic signed [W_DATA-1:0] r4_pos;
    logic                     r4_active;

    // stage 5
    logic signed [50:0]       n5_hi;
    logic        [63:0]       n5_lo;
    logic signed [50:0]       r5_hi;
    logic        [63:0]       r5_lo;
    logic signed [W_BASE-1:0] r5_base;
    logic signed [W_DATA-1:0] r5_pos;
    logic                     r5_active;

    // stage 6
    logic signed [52:0]       n6_sum;
    logic signed [W_DATA-1:0] n6_vel;
    logic signed [W_DATA-1:0] r6_vel;
    logic signed [W_DATA-1:0] r6_pos;

    // stage 7
    logic signed [64:0]       n7_prod;
    logic signed [64:0]       r7_prod;
    logic signed [W_DATA-1:0] r7_vel;
    logic signed [W_DATA-1:0] r7_pos;

    // stage 8
    logic signed [W_DATA-1:0] n8_pos;
    logic signed [W_DATA-1:0] r8_vel;
    logic signed [W_DATA-1:0] r8_pos;

    assign dt_s = $signed({1'b0, i_time_step});

    assign n4_br = 50'(i_mid.fm_sh) - 50'(i_mid.dot_sh);

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[ST_BR]) begin
            r4_br     <= n4_br;
            r4_base   <= i_mid.base;
            r4_pos    <= i_mid.pos;
            r4_active <= i_mid.active;
        end
    end

    // br*dt split as hi*2^32 + lo, so floor(br*dt/2^32) = hi*dt + (lo*dt >> 32)
    assign n5_hi = $signed(r4_br[49:32]) * dt_s;
    assign n5_lo = r4_br[31:0] * i_time_step;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[ST_BRMUL]) begin
            r5_hi     <= n5_hi;
            r5_lo     <= n5_lo;
            r5_base   <= r4_base;
            r5_pos    <= r4_pos;
            r5_active <= r4_active;
        end
    end

    // a frozen or inert axis gets zero velocity, which also leaves pos untouched
    assign n6_sum = 53'(r5_hi) + 53'($signed({1'b0, r5_lo[63:32]})) + 53'(r5_base);
    assign n6_vel = r5_active ? sat32(64'(n6_sum)) : '0;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[ST_VEL]) begin
            r6_vel <= n6_vel;
            r6_pos <= r5_pos;
        end
    end

    assign n7_prod = r6_vel * dt_s;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[ST_POSMUL]) begin
            r7_prod <= n7_prod;
            r7_vel  <= r6_vel;
            r7_pos  <= r6_pos;
        end
    end

    assign n8_pos = sat32(64'(r7_pos) + 64'($signed(r7_prod[64:32])));

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[ST_OUT]) begin
            r8_vel <= r7_vel;
            r8_pos <= n8_pos;
        end
    end

    assign o_vel = r8_vel;
    assign o_pos = r8_pos;

endmodule

// ----- rtl/leapfrog_particle_update.sv -----
// ----------------------------------------------------------------------------
// leapfrog_particle_update: leapfrog particle update with T and P coupling
// pipeline: eight register stages between an input transaction and its result
// throughput: one particle per cycle while the result side is ready
// reset: clears the pipeline valid bits, loads the configuration defaults
// ----------------------------------------------------------------------------
module leapfrog_particle_update (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    lpu_particle_if.sink                     i_particle,
    lpu_result_if.source                     o_result,
    input  logic                             i_cfg_we,
    input  logic [lpu_pkg::W_CFG_IDX-1:0]    i_cfg_idx,
    input  logic [lpu_pkg::W_CFG_DATA-1:0]   i_cfg_data
);
    import lpu_pkg::*;

    // stage map
    //   1  vrel = sat(v - u), active mask from freeze bits and type codes
    //   2  row products, invmass*f, lambda*vrel, accel*dt
    //   3  dot sums and floor shifts, base = u + accel*dt + lambda term
    //   4  bracket br = invmass*f - row.vrel
    //   5  br*dt as two partial products
    //   6  new velocity, saturated, zeroed on inactive axes
    //   7  new velocity times dt
    //   8  new position, saturated (output register)

    t_cfg                     cfg;
    t_pipe_ctl                ctl;
    logic [N_STAGES-1:0]      load;
    logic [N_STAGES-1:0]      r_v;
    logic [N_STAGES-1:0]      n_v;
    t_axis_mid                mid [N_AXES];
    logic signed [W_DATA-1:0] vel [N_AXES];
    logic signed [W_DATA-1:0] pos [N_AXES];

    // a stage loads when it is empty or when its content moves on; bubbles
    // collapse, so input transactions continue while a result waits, until all stages fill
    always_comb begin
        load[N_STAGES-1] = !r_v[N_STAGES-1] || o_result.ready;
        for (int s = N_STAGES - 2; s >= 0; s--) begin
            load[s] = !r_v[s] || load[s+1];
        end
    end

    assign ctl.load = load;

    // valid bits travel alongside the data
    always_comb begin
        n_v = r_v;
        if (load[0]) begin
            n_v[0] = i_particle.valid;
        end
        for (int s = 1; s < N_STAGES; s++) begin
            if (load[s]) begin
                n_v[s] = r_v[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= n_v;
        end
    end

    // no transaction is taken while in reset
    assign i_particle.ready = load[0] && i_rst_n;
    assign o_result.valid   = r_v[N_STAGES-1];

    lpu_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    // shared front end for all three axes
    lpu_front u_front (
        .i_clk  (i_clk),
        .i_ctl  (ctl),
        .i_cfg  (cfg),
        .i_part (i_particle.data),
        .o_mid  (mid)
    );

    // one back end per axis
    for (genvar d = 0; d < N_AXES; d++) begin : g_axis
        lpu_axis u_axis (
            .i_clk       (i_clk),
            .i_ctl       (ctl),
            .i_time_step (cfg.time_step),
            .i_mid       (mid[d]),
            .o_vel       (vel[d]),
            .o_pos       (pos[d])
        );
    end

    assign o_result.data.new_vel_x = vel[0];
    assign o_result.data.new_vel_y = vel[1];
    assign o_result.data.new_vel_z = vel[2];
    assign o_result.data.new_pos_x = pos[0];
    assign o_result.data.new_pos_y = pos[1];
    assign o_result.data.new_pos_z = pos[2];

`ifndef NO_ASSERTIONS
    // occupancy changes only by transactions in and out
    a_occupancy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> ($countones(r_v) == $past($countones(r_v))
            + $past(i_particle.valid && i_particle.ready)
            - $past(o_result.valid && o_result.ready)))
        else $error("pipeline occupancy mismatch");

    // a full pipeline with a stalled output takes nothing in
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((&r_v) && !o_result.ready) |-> !i_particle.ready)
        else $error("input taken while pipeline full and stalled");

    // an accepted transaction lands in the first stage
    a_capture: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_particle.valid && i_particle.ready) |=> r_v[ST_VREL])
        else $error("accepted transaction not captured");

    // reset leaves the pipeline empty
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_v == '0))
        else $error("pipeline not empty after reset");
`endif

endmodule
